/* rtl/core/moving_average_filter_macros.svh */
// Assertion helpers for the moving average filter checks.
// Both sample on the rising edge of aclk and stay quiet while aresetn is low.
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define MAF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/maf_pkg.sv */
`default_nettype none

package maf_pkg;

    // Default sizes
    localparam int WINDOW_MAX_DEF    = 64;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int CFG_W           = 7;
    localparam int OUT_W           = 24;
    localparam int LEN_RESET_DEF   = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } maf_state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_div;
        logic step_div;
        logic load_out;
    } maf_cmd_t;

    typedef struct packed {
        logic div_last;
    } maf_stat_t;

endpackage

`default_nettype wire

/* rtl/core/maf_ram.sv */
`default_nettype none

module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/maf_ctrl.sv */
`default_nettype none

module maf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output maf_pkg::maf_cmd_t     cmd,
    input  wire maf_pkg::maf_stat_t stat
);

    import maf_pkg::*;

    maf_state_t state_reg;
    maf_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_div = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.step_div = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait for the output slot to free up
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/maf_dp.sv */
`default_nettype none

module maf_dp #(
    parameter int WINDOW_MAX    = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = maf_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = maf_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [maf_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic signed [SAMPLE_BITS-1:0]   s_sample,
    output logic signed [maf_pkg::OUT_W-1:0]     m_average,
    input  wire maf_pkg::maf_cmd_t               cmd,
    output maf_pkg::maf_stat_t                   stat
);

    import maf_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = LEN_W + 1;
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int SUM_W = SAMPLE_BITS + PTR_W + 1;
    localparam int MAG_W = SUM_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(MAG_W);
    localparam int EXT_W = ((MAG_W > OUT_W) ? MAG_W : OUT_W) + 1;
    localparam int LEN_RESET = (LEN_RESET_DEF > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET_DEF;

    localparam logic [EXT_W-1:0] NEG_MAG = EXT_W'(1) << (OUT_W - 1);
    localparam logic [EXT_W-1:0] POS_LIM = NEG_MAG - EXT_W'(1);
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    logic [LEN_W-1:0]              len_reg;
    logic [LEN_W-1:0]              len_next;
    logic [PTR_W-1:0]              wp_reg;
    logic [WINDOW_MAX-1:0]         valid_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          leave_valid_reg;
    logic [MAG_W-1:0]              q_reg;
    logic [MAG_W-1:0]              q_next;
    logic [LEN_W-1:0]              r_reg;
    logic [LEN_W-1:0]              r_next;
    logic                          neg_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [OUT_W-1:0]              avg_reg;
    logic [OUT_W-1:0]              avg_next;

    logic [CMP_W-1:0]              cfg_ext;
    logic [IDX_W-1:0]              idx_diff;
    logic [PTR_W-1:0]              leave_idx;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic signed [MAG_W-1:0]       scaled;
    logic [MAG_W-1:0]              mag;
    logic [IDX_W-1:0]              trial;
    logic [IDX_W-1:0]              div_ext;
    logic                          ge;
    logic [EXT_W-1:0]              q_ext;

    // Clamp the written window length into 1..WINDOW_MAX
    always_comb begin
        cfg_ext = CMP_W'(cfg_wr_data);
        if (cfg_ext == '0) begin
            len_next = LEN_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            len_next = LEN_W'(WINDOW_MAX);
        end else begin
            len_next = LEN_W'(cfg_ext);
        end
    end

    // Slot that drops out of the window: wp - len, wrapped
    assign idx_diff  = IDX_W'(wp_reg) - IDX_W'(len_reg);
    assign leave_idx = idx_diff[IDX_W-1] ? PTR_W'(idx_diff + IDX_W'(WINDOW_MAX))
                                         : PTR_W'(idx_diff);

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_maf_store (
        .aclk    (aclk),
        .wr_en   (cmd.update),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (cmd.accept),
        .rd_addr (leave_idx),
        .rd_data (rd_data)
    );

    assign old_val  = leave_valid_reg ? signed'(rd_data) : '0;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);

    assign scaled = MAG_W'(sum_reg) <<< FRACTION_BITS;
    assign mag    = scaled[MAG_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);

    // One restoring divide step per cycle
    assign trial   = {r_reg, q_reg[MAG_W-1]};
    assign div_ext = IDX_W'(len_reg);
    assign ge      = (trial >= div_ext);
    assign r_next  = ge ? LEN_W'(trial - div_ext) : LEN_W'(trial);
    assign q_next  = {q_reg[MAG_W-2:0], ge};

    // Restore the sign and saturate to the output range
    always_comb begin
        q_ext = EXT_W'(q_reg);
        if (neg_reg) begin
            avg_next = (q_ext > NEG_MAG) ? OUT_MIN : OUT_W'(EXT_W'(0) - q_ext);
        end else begin
            avg_next = (q_ext > POS_LIM) ? OUT_MAX : OUT_W'(q_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LEN_W'(LEN_RESET);
            wp_reg    <= '0;
            valid_reg <= '0;
            sum_reg   <= '0;
        end else if (cfg_wr_en) begin
            // A new length restarts the window from zeros
            len_reg   <= len_next;
            wp_reg    <= '0;
            valid_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.update) begin
            sum_reg           <= sum_next;
            valid_reg[wp_reg] <= 1'b1;
            wp_reg            <= (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg      <= s_sample;
            leave_valid_reg <= valid_reg[leave_idx];
        end
        if (cmd.load_div) begin
            q_reg   <= mag;
            r_reg   <= '0;
            neg_reg <= scaled[MAG_W-1];
            cnt_reg <= CNT_W'(MAG_W - 1);
        end else if (cmd.step_div) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.load_out) begin
            avg_reg <= avg_next;
        end
    end

    assign stat.div_last = (cnt_reg == '0);
    assign m_average     = signed'(avg_reg);

endmodule

`default_nettype wire

/* rtl/core/moving_average_filter.sv */
// Boxcar moving average over the most recent window_length signed samples.
//
// Input channel s_valid/s_ready/s_sample: one beat is one sensor sample.
// Result channel m_valid/m_ready/m_average: one beat per input beat, the
// window sum times 2^FRACTION_BITS divided by window_length, truncated toward
// zero and saturated to 24 signed bits.
// Configuration: cfg_wr_en/cfg_wr_data write window_length (0 reads as 1,
// values above WINDOW_MAX clamp to WINDOW_MAX) and restart the window from
// zeros. Write it only while no sample is in flight.
//
// Timing: the accept cycle reads the leaving sample, the update state adds
// the new sample to the running sum and writes it to the window store, the
// load state loads the bit-serial divider, which then develops a quotient of
// SAMPLE_BITS + $clog2(WINDOW_MAX) + 1 + FRACTION_BITS bits one bit at a
// time, and the done state hands the quotient to the output register. The
// block takes no new sample until the previous one has reached that register.
// Reset clears the window, write position and running sum and sets
// window_length to 8, or to WINDOW_MAX if less. A result that is not taken
// sits in the output register while the next sample is accepted and processed;
// that sample's result then waits in the divider until the register frees up.
`default_nettype none

module moving_average_filter #(
    parameter int WINDOW_MAX    = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = maf_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = maf_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [maf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [maf_pkg::OUT_W-1:0]   m_average
);

    import maf_pkg::*;

    maf_cmd_t  cmd;
    maf_stat_t stat;

    // Sequencer: accept, update, divide, hand off to the output register
    maf_ctrl u_maf_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Window store, running sum, serial divider and output register
    maf_dp #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_maf_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_sample),
        .m_average   (m_average),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

/* rtl/core/maf_checker.sv */
`include "moving_average_filter_macros.svh"
`default_nettype none

module maf_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [maf_pkg::OUT_W-1:0]   m_average
);

    // Hold a stalled result
    `MAF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_average), "stalled result changed")

    // Stay busy for the sum update, divider load and divide after a beat
    `MAF_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready ##1 !s_ready ##1 !s_ready, "input taken too soon after previous beat")

    // A new result only shows up at the end of a busy stretch
    `MAF_ASSERT_SAME(a_out_after_work, $rose(m_valid), $past(!s_ready), "result appeared without work in flight")

    // Leave reset with the output empty
    `MAF_ASSERT_SAME(a_reset_empty, $rose(aresetn), !m_valid, "result valid right after reset")

endmodule

bind moving_average_filter maf_checker u_maf_checker (.*);

`default_nettype wire
